@@ rtl/sce_pkg.sv @@
// Shared types and constants for the sigma-clipped standard error block.
// Holds field widths, register indexes, the controller command and status structs.
// No dependencies.
package sce_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int SIGMA_W    = 31;
  localparam int KEPT_W     = 5;
  localparam int COUNT_W    = 5;
  localparam int CLIP_W     = 8;
  localparam int FLOOR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_FLOOR   = 2'd2;

  typedef enum logic [1:0] {
    SRC_MEAN_ALL,
    SRC_MEAN_KEPT,
    SRC_VAR_ALL,
    SRC_VAR_KEPT
  } div_src_t;

  typedef struct packed {
    logic     load;
    logic     start_set;
    logic     div_start;
    div_src_t div_src;
    logic     cap_mean;
    logic     cap_km;
    logic     idx_clr;
    logic     idx_inc;
    logic     acc_clr;
    logic     use_km;
    logic     diff_en;
    logic     sq_en;
    logic     acc_add;
    logic     sqrt_start;
    logic     cap_sigma;
    logic     sigma_zero;
    logic     clip_eval;
    logic     cap_err;
    logic     err_zero;
    logic     out_load;
  } sce_cmd_t;

  typedef struct packed {
    logic close;
    logic div_busy;
    logic sqrt_busy;
    logic n_ge2;
    logic k_ge2;
    logic idx_last;
    logic out_free;
  } sce_status_t;

endpackage

@@ rtl/sce_ctrl.sv @@
// Controller state machine for the sigma-clipped standard error block.
// Sequences loading, the statistics passes, division and square root.
// Depends on sce_pkg.
module sce_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sce_pkg::sce_status_t st,
  output sce_pkg::sce_cmd_t    cmd
);
  import sce_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_MEAN1,
    S_DV_RD,
    S_DV_DIFF,
    S_DV_SQ,
    S_DV_ACC,
    S_DV_END,
    S_DV_DIV,
    S_DV_SQRT,
    S_CL_RD,
    S_CL_DIFF,
    S_CL_EVAL,
    S_CL_END,
    S_MEAN2,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    in_stall   = (state_r != S_LOAD);
    cmd.use_km = pass_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.close) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start_set = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_src   = SRC_MEAN_ALL;
        pass_nxt      = 1'b0;
        state_nxt     = S_MEAN1;
      end
      S_MEAN1: begin
        if (!st.div_busy) begin
          cmd.cap_mean = 1'b1;
          cmd.idx_clr  = 1'b1;
          if (st.n_ge2) begin
            cmd.acc_clr = 1'b1;
            state_nxt   = S_DV_RD;
          end else begin
            cmd.sigma_zero = 1'b1;
            state_nxt      = S_CL_RD;
          end
        end
      end
      S_DV_RD: state_nxt = S_DV_DIFF;
      S_DV_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_DV_SQ;
      end
      S_DV_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_DV_ACC;
      end
      S_DV_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = st.idx_last ? S_DV_END : S_DV_RD;
      end
      S_DV_END: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = pass_r ? SRC_VAR_KEPT : SRC_VAR_ALL;
        state_nxt     = S_DV_DIV;
      end
      S_DV_DIV: begin
        if (!st.div_busy) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_DV_SQRT;
        end
      end
      S_DV_SQRT: begin
        if (!st.sqrt_busy) begin
          if (pass_r) begin
            cmd.cap_err = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            cmd.cap_sigma = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_nxt     = S_CL_RD;
          end
        end
      end
      S_CL_RD: state_nxt = S_CL_DIFF;
      S_CL_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_CL_EVAL;
      end
      S_CL_EVAL: begin
        cmd.clip_eval = 1'b1;
        cmd.idx_inc   = 1'b1;
        state_nxt     = st.idx_last ? S_CL_END : S_CL_RD;
      end
      S_CL_END: begin
        if (st.k_ge2) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = SRC_MEAN_KEPT;
          state_nxt     = S_MEAN2;
        end else begin
          cmd.err_zero = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_MEAN2: begin
        if (!st.div_busy) begin
          cmd.cap_km  = 1'b1;
          cmd.idx_clr = 1'b1;
          cmd.acc_clr = 1'b1;
          pass_nxt    = 1'b1;
          state_nxt   = S_DV_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

@@ rtl/sce_datapath.sv @@
// Datapath for the sigma-clipped standard error block: sample memory, sums,
// shared restoring divider, shared integer square root and output register.
// Depends on sce_pkg; driven by sce_ctrl commands.
module sce_datapath #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sce_pkg::sce_cmd_t                     cmd,
  output sce_pkg::sce_status_t                  st,
  input  logic signed [sce_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic                                  in_last_sample,
  input  logic [sce_pkg::COUNT_W-1:0]           sample_count,
  input  logic [sce_pkg::CLIP_W-1:0]            clip_factor,
  input  logic [sce_pkg::FLOOR_W-1:0]           mean_floor,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [sce_pkg::SAMPLE_W-1:0]   out_mean_value,
  output logic [sce_pkg::SIGMA_W-1:0]           out_sigma_value,
  output logic [sce_pkg::KEPT_W-1:0]            out_kept_count,
  output logic [sce_pkg::SIGMA_W-1:0]           out_std_error,
  output logic                                  out_too_few_kept
);
  import sce_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int ACC_W  = 64 + CNT_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int DCNT_W = $clog2(ACC_W);

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [CNT_W-1:0]           cnt_r, n_r, k_r, limit;
  logic signed [SUM_W-1:0]    sum_r, ksum_r;
  logic [IDX_W-1:0]           idx_r;
  logic [MAX_SAMPLES-1:0]     keep_r;
  logic signed [SAMPLE_W-1:0] m_r, km_r, mean_sel, q_mean;
  logic [SAMPLE_W-1:0]        mabs;
  logic                       active_r;
  logic signed [SAMPLE_W:0]   dif, negd;
  logic [31:0]                diff_r;
  logic [63:0]                sq_r, sq_prod;
  logic [ACC_W-1:0]           acc_r;
  logic [39:0]                thr_r, d16;
  logic                       clip_drop;
  logic [31:0]                sigma_r, err_r;

  logic [ACC_W-1:0]  div_num_r, div_num_sel;
  logic [DEN_W-1:0]  div_den_r, div_den_sel, div_rem_r;
  logic [DEN_W:0]    div_rem_sh, div_sub;
  logic              div_ge, div_busy_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [63:0]       div_sat;

  logic [63:0] sq_x_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [35:0] sq_sh, sq_trial, sq_diff;
  logic        sq_ge, sqrt_busy_r;
  logic [4:0]  sq_cnt_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_mean_r;
  logic [SIGMA_W-1:0]         out_sigma_r, out_err_r;
  logic [KEPT_W-1:0]          out_kept_r;
  logic                       out_few_r;

  function automatic logic [ACC_W-1:0] mean_num(logic signed [SUM_W-1:0] s,
                                                 logic [CNT_W-1:0] c);
    logic [ACC_W-1:0] u;
    u = {{(ACC_W-SUM_W){s[SUM_W-1]}}, s} + (ACC_W'(c) << 31);
    return (u << 1) + ACC_W'(c);
  endfunction

  function automatic logic [SIGMA_W-1:0] sat31(logic [31:0] v);
    return v[31] ? {SIGMA_W{1'b1}} : v[SIGMA_W-1:0];
  endfunction

  always_comb begin
    if (sample_count == '0) begin
      limit = CNT_W'(1);
    end else if (32'(sample_count) > 32'(MAX_SAMPLES)) begin
      limit = CNT_W'(MAX_SAMPLES);
    end else begin
      limit = CNT_W'(sample_count);
    end
  end

  assign st.close     = in_last_sample || ((cnt_r + CNT_W'(1)) >= limit);
  assign st.div_busy  = div_busy_r;
  assign st.sqrt_busy = sqrt_busy_r;
  assign st.n_ge2     = (n_r >= CNT_W'(2));
  assign st.k_ge2     = (k_r >= CNT_W'(2));
  assign st.idx_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == n_r);
  assign st.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[cnt_r[IDX_W-1:0]] <= in_sample_value;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= cnt_r + CNT_W'(1);
      sum_r <= sum_r + {{(SUM_W-SAMPLE_W){in_sample_value[SAMPLE_W-1]}}, in_sample_value};
    end else if (cmd.start_set) begin
      cnt_r <= '0;
      sum_r <= '0;
    end
  end

  always_comb begin
    case (cmd.div_src)
      SRC_MEAN_ALL: begin
        div_num_sel = mean_num(sum_r, cnt_r);
        div_den_sel = DEN_W'({cnt_r, 1'b0});
      end
      SRC_MEAN_KEPT: begin
        div_num_sel = mean_num(ksum_r, k_r);
        div_den_sel = DEN_W'({k_r, 1'b0});
      end
      SRC_VAR_ALL: begin
        div_num_sel = acc_r;
        div_den_sel = DEN_W'(n_r - CNT_W'(1));
      end
      SRC_VAR_KEPT: begin
        div_num_sel = acc_r;
        div_den_sel = DEN_W'(k_r) * DEN_W'(k_r - CNT_W'(1));
      end
      default: begin
        div_num_sel = acc_r;
        div_den_sel = DEN_W'(1);
      end
    endcase
  end

  assign div_rem_sh = {div_rem_r, div_num_r[ACC_W-1]};
  assign div_sub    = div_rem_sh - {1'b0, div_den_r};
  assign div_ge     = (div_rem_sh >= {1'b0, div_den_r});
  assign div_sat    = (|div_num_r[ACC_W-1:64]) ? '1 : div_num_r[63:0];
  assign q_mean     = {~div_num_r[SAMPLE_W-1], div_num_r[SAMPLE_W-2:0]};
  assign mabs       = q_mean[SAMPLE_W-1] ? (~q_mean + 1'b1) : q_mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == DCNT_W'(ACC_W - 1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num_r <= div_num_sel;
      div_den_r <= div_den_sel;
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_num_r <= {div_num_r[ACC_W-2:0], div_ge};
      div_rem_r <= div_ge ? div_sub[DEN_W-1:0] : div_rem_sh[DEN_W-1:0];
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  assign sq_sh    = {sq_rem_r, sq_x_r[63:62]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_diff  = sq_sh - sq_trial;
  assign sq_ge    = (sq_sh >= sq_trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqrt_busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy_r <= 1'b1;
    end else if (sqrt_busy_r && sq_cnt_r == 5'd31) begin
      sqrt_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_x_r    <= div_sat;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= '0;
    end else if (sqrt_busy_r) begin
      sq_x_r    <= {sq_x_r[61:0], 2'b00};
      sq_rem_r  <= sq_ge ? sq_diff[33:0] : sq_sh[33:0];
      sq_root_r <= {sq_root_r[30:0], sq_ge};
      sq_cnt_r  <= sq_cnt_r + 5'd1;
    end
  end

  assign mean_sel  = cmd.use_km ? km_r : m_r;
  assign dif       = {rd_data_r[SAMPLE_W-1], rd_data_r} - {mean_sel[SAMPLE_W-1], mean_sel};
  assign negd      = -dif;
  assign sq_prod   = diff_r * diff_r;
  assign d16       = {4'b0000, diff_r, 4'b0000};
  assign clip_drop = active_r && (d16 > thr_r);

  always_ff @(posedge clk) begin
    if (cmd.start_set) begin
      n_r    <= cnt_r;
      k_r    <= '0;
      ksum_r <= '0;
    end else if (cmd.clip_eval && !clip_drop) begin
      k_r    <= k_r + CNT_W'(1);
      ksum_r <= ksum_r + {{(SUM_W-SAMPLE_W){rd_data_r[SAMPLE_W-1]}}, rd_data_r};
    end
    if (cmd.clip_eval) begin
      keep_r[idx_r] <= !clip_drop;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.cap_mean) begin
      m_r      <= q_mean;
      active_r <= (mabs > {{(SAMPLE_W-FLOOR_W){1'b0}}, mean_floor});
    end
    if (cmd.cap_km) begin
      km_r <= q_mean;
    end
    if (cmd.diff_en) begin
      diff_r <= dif[SAMPLE_W] ? negd[31:0] : dif[31:0];
    end
    if (cmd.sq_en) begin
      sq_r <= sq_prod;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add && (!cmd.use_km || keep_r[idx_r])) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
    if (cmd.cap_sigma) begin
      sigma_r <= sq_root_r;
      thr_r   <= 40'(clip_factor) * 40'(sq_root_r);
    end else if (cmd.sigma_zero) begin
      sigma_r <= '0;
      thr_r   <= '0;
    end
    if (cmd.cap_err) begin
      err_r <= sq_root_r;
    end else if (cmd.err_zero) begin
      err_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean_r  <= m_r;
      out_sigma_r <= sat31(sigma_r);
      out_kept_r  <= KEPT_W'(k_r);
      out_err_r   <= sat31(err_r);
      out_few_r   <= (k_r < CNT_W'(2));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mean_value   = out_mean_r;
  assign out_sigma_value  = out_sigma_r;
  assign out_kept_count   = out_kept_r;
  assign out_std_error    = out_err_r;
  assign out_too_few_kept = out_few_r;

endmodule

@@ rtl/sigma_clipped_standard_error_top.sv @@
// Top level of the sigma-clipped standard error block.
// Holds the configuration registers and joins sce_ctrl with sce_datapath.
// Depends on sce_pkg, sce_ctrl and sce_datapath.
//
// Usage: samples arrive on the in_ channel, one per transaction, and are
// stored one per cycle. A set closes on a transaction with in_last_sample
// set or when the configured sample count is reached. The block then
// stalls the input while it computes the mean, sigma, the clip pass and the
// standard error, and delivers one result transaction on the out_ channel.
// The closing work rests on the one-bit-per-cycle divider, run up to four
// times over ACC_W bits (64 plus the count width, 69 at 16 samples), and
// on the one-bit-per-cycle square root, run up to twice.
// The finished result sits in an output register, so loading of the next
// set starts while it waits; a second result waits inside until the first
// is taken. Configuration writes are always ready and take effect at once.
// Reset clears the control state and loads the register defaults (16
// samples, clip factor 2.5, mean floor 107).
module sigma_clipped_standard_error_top #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sce_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic                                  in_last_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sce_pkg::SAMPLE_W-1:0]   out_mean_value,
  output logic [sce_pkg::SIGMA_W-1:0]           out_sigma_value,
  output logic [sce_pkg::KEPT_W-1:0]            out_kept_count,
  output logic [sce_pkg::SIGMA_W-1:0]           out_std_error,
  output logic                                  out_too_few_kept,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sce_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import sce_pkg::*;

  logic [COUNT_W-1:0] sample_count_r;
  logic [CLIP_W-1:0]  clip_factor_r;
  logic [FLOOR_W-1:0] mean_floor_r;
  sce_cmd_t           cmd;
  sce_status_t        st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= COUNT_W'(16);
      clip_factor_r  <= CLIP_W'(40);
      mean_floor_r   <= FLOOR_W'(107);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[COUNT_W-1:0];
        CFG_CLIP_FACTOR:  clip_factor_r  <= cfg_data[CLIP_W-1:0];
        CFG_MEAN_FLOOR:   mean_floor_r   <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  sce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sce_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_sample_value  (in_sample_value),
    .in_last_sample   (in_last_sample),
    .sample_count     (sample_count_r),
    .clip_factor      (clip_factor_r),
    .mean_floor       (mean_floor_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_mean_value   (out_mean_value),
    .out_sigma_value  (out_sigma_value),
    .out_kept_count   (out_kept_count),
    .out_std_error    (out_std_error),
    .out_too_few_kept (out_too_few_kept)
  );

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> st.div_busy)
    else $error("divider did not start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!st.div_busy && !st.sqrt_busy))
    else $error("sample loaded while arithmetic units busy");

  a_sqrt_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |-> !st.div_busy)
    else $error("square root started before division finished");

endmodule
